[rtl/palette_rle_sprite_decoder_unit_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the palette RLE sprite decoder
// Shared concurrent assertion forms, clocked on the rising edge and
// disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef PALETTE_RLE_SPRITE_DECODER_UNIT_DEFINES_SVH
`define PALETTE_RLE_SPRITE_DECODER_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PRS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("prs: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define PRS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("prs: next-cycle check failed");

`endif

[rtl/prs_pkg.sv]
// ----------------------------------------------------------------------------
// prs_pkg
// Types, codes and defaults shared by the sprite decoder modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package prs_pkg;

   localparam int PALETTE_DEPTH_DEF = 256;
   localparam int POSITION_BITS_DEF = 21;
   localparam int FRAME_W           = 21;
   localparam int QUEUE_DEPTH       = 4;

   localparam logic [7:0]  CTRL_BASE   = 8'h80;
   localparam logic [7:0]  ALPHA_OPAQUE = 8'hFF;
   localparam logic [7:0]  ALPHA_CLEAR  = 8'h00;

   localparam logic        CMD_PALETTE = 1'b0;
   localparam logic        CMD_FRAME   = 1'b1;

   localparam logic [1:0]  MODE_RGB  = 2'd0;
   localparam logic [1:0]  MODE_RGBA = 2'd1;
   localparam logic [1:0]  MODE_BGRA = 2'd2;

   localparam logic [1:0]  ERR_OK      = 2'd0;
   localparam logic [1:0]  ERR_OVERRUN = 2'd1;
   localparam logic [1:0]  ERR_TRUNC   = 2'd2;

   localparam int          CSR_INDEX_W = 3;
   localparam logic [2:0]  REG_KEY_RED      = 3'd0;
   localparam logic [2:0]  REG_KEY_GREEN    = 3'd1;
   localparam logic [2:0]  REG_KEY_BLUE     = 3'd2;
   localparam logic [2:0]  REG_OUT_MODE     = 3'd3;
   localparam logic [2:0]  REG_FRAME_PIXELS = 3'd4;

   localparam logic [FRAME_W-1:0] FRAME_PIXELS_RST = 21'd1048576;
   localparam logic [7:0]         KEY_RST          = 8'd255;

   typedef enum logic [1:0] {
      KIND_WRITE,
      KIND_KEY,
      KIND_PIXEL,
      KIND_MARKER
   } kind_type;

   typedef struct packed {
      logic       cmd;
      logic [7:0] pal_index;
      logic [7:0] pal_red;
      logic [7:0] pal_green;
      logic [7:0] pal_blue;
      logic [7:0] code_byte;
      logic       frame_end;
   } req_type;

   typedef struct packed {
      logic [7:0] chan_first;
      logic [7:0] chan_second;
      logic [7:0] chan_third;
      logic [7:0] alpha;
      logic [6:0] repeat_res;
      logic       end_of_frame;
      logic [1:0] error_code;
   } rsp_type;

   // one classified item between front and back
   typedef struct packed {
      kind_type    kind;
      logic [7:0]  index;
      logic [23:0] rgb;
      logic        in_range;
      logic [6:0]  repeat_res;
      logic        end_of_frame;
      logic [1:0]  error_code;
   } entry_type;

   typedef struct packed {
      logic [7:0] key_red;
      logic [7:0] key_green;
      logic [7:0] key_blue;
      logic [1:0] out_mode;
   } cfg_type;

endpackage

[rtl/prs_ram.sv]
// ----------------------------------------------------------------------------
// prs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module prs_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/prs_front.sv]
// ----------------------------------------------------------------------------
// prs_front
// Accepts items, tracks run state and frame position, classifies results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module prs_front #(
   parameter int PALETTE_DEPTH = prs_pkg::PALETTE_DEPTH_DEF,
   parameter int POSITION_BITS = prs_pkg::POSITION_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  prs_pkg::req_type              req_payload,
   input  logic [prs_pkg::FRAME_W-1:0]   frame_pixels,
   input  logic                          queue_full,
   output logic                          push,
   output prs_pkg::entry_type            push_entry
);

   localparam int LIM_W = (POSITION_BITS > prs_pkg::FRAME_W) ? POSITION_BITS
                                                             : prs_pkg::FRAME_W;

   logic [7:0]               lit_ff, lit_in;
   logic [POSITION_BITS-1:0] pos_ff, pos_in;
   logic                     ovs_ff, ovs_in;

   logic                     accept;
   logic [LIM_W-1:0]         fp_ext, max_ext, lim_wide;
   logic [POSITION_BITS-1:0] lim;
   logic [6:0]               step_n;
   logic [POSITION_BITS:0]   np;
   logic                     over;
   logic [7:0]               lit_dec;
   logic                     idx_ok, code_ok;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;

   // limit is frame_pixels capped to the largest position value
   assign fp_ext   = LIM_W'(frame_pixels);
   assign max_ext  = LIM_W'({POSITION_BITS{1'b1}});
   assign lim_wide = (fp_ext > max_ext) ? max_ext : fp_ext;
   assign lim      = lim_wide[POSITION_BITS-1:0];

   assign step_n  = (lit_ff == 8'd0) ? req_payload.code_byte[6:0] : 7'd1;
   assign np      = {1'b0, pos_ff} + (POSITION_BITS + 1)'(step_n);
   assign over    = np > {1'b0, lim};
   assign lit_dec = lit_ff - 8'd1;

   assign idx_ok  = {1'b0, req_payload.pal_index} < 9'(PALETTE_DEPTH);
   assign code_ok = {1'b0, req_payload.code_byte} < 9'(PALETTE_DEPTH);

   always_comb begin
      lit_in     = lit_ff;
      pos_in     = pos_ff;
      ovs_in     = ovs_ff;
      push       = 1'b0;
      push_entry = '0;
      push_entry.index        = req_payload.code_byte;
      push_entry.rgb          = {req_payload.pal_red, req_payload.pal_green,
                                 req_payload.pal_blue};
      push_entry.in_range     = code_ok;
      push_entry.end_of_frame = req_payload.frame_end;
      push_entry.error_code   = prs_pkg::ERR_OK;
      if (accept) begin
         if (req_payload.cmd == prs_pkg::CMD_PALETTE) begin
            push                = 1'b1;
            push_entry.kind     = prs_pkg::KIND_WRITE;
            push_entry.index    = req_payload.pal_index;
            push_entry.in_range = idx_ok;
         end else if (lit_ff == 8'd0) begin
            if (req_payload.code_byte > prs_pkg::CTRL_BASE) begin
               push                  = 1'b1;
               push_entry.kind       = prs_pkg::KIND_KEY;
               push_entry.repeat_res = step_n;
               if (over || ovs_ff) begin
                  push_entry.error_code = prs_pkg::ERR_OVERRUN;
               end
               if (over) begin
                  pos_in = lim;
                  ovs_in = 1'b1;
               end else begin
                  pos_in = np[POSITION_BITS-1:0];
               end
            end else if (req_payload.frame_end) begin
               push            = 1'b1;
               push_entry.kind = prs_pkg::KIND_MARKER;
               if (req_payload.code_byte != 8'd0) begin
                  push_entry.error_code = prs_pkg::ERR_TRUNC;
               end else if (ovs_ff) begin
                  push_entry.error_code = prs_pkg::ERR_OVERRUN;
               end
            end else begin
               lit_in = req_payload.code_byte;
            end
         end else begin
            push                  = 1'b1;
            push_entry.kind       = prs_pkg::KIND_PIXEL;
            push_entry.repeat_res = 7'd1;
            lit_in                = lit_dec;
            if (over || ovs_ff) begin
               push_entry.error_code = prs_pkg::ERR_OVERRUN;
            end else if (req_payload.frame_end && lit_dec != 8'd0) begin
               push_entry.error_code = prs_pkg::ERR_TRUNC;
            end
            if (over) begin
               pos_in = lim;
               ovs_in = 1'b1;
            end else begin
               pos_in = np[POSITION_BITS-1:0];
            end
         end
         // frame end resets decode state; palette writes leave it alone
         if (req_payload.cmd == prs_pkg::CMD_FRAME && req_payload.frame_end) begin
            lit_in = 8'd0;
            pos_in = '0;
            ovs_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lit_ff <= 8'd0;
         pos_ff <= '0;
         ovs_ff <= 1'b0;
      end else begin
         lit_ff <= lit_in;
         pos_ff <= pos_in;
         ovs_ff <= ovs_in;
      end
   end

endmodule

[rtl/prs_fifo.sv]
// ----------------------------------------------------------------------------
// prs_fifo
// Short queue of classified entries between front and back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "palette_rle_sprite_decoder_unit_defines.svh"

module prs_fifo (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  prs_pkg::entry_type push_entry,
   output logic               full,
   input  logic               pop,
   output logic               head_valid,
   output prs_pkg::entry_type head_entry
);

   localparam int DEPTH = prs_pkg::QUEUE_DEPTH;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   prs_pkg::entry_type entries_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;

   assign full       = cnt_ff == CNT_W'(DEPTH);
   assign head_valid = cnt_ff != '0;
   assign head_entry = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   `PRS_ASSERT_NOW(a_no_push_full, clock, reset, push, !full)
   `PRS_ASSERT_NOW(a_no_pop_empty, clock, reset, pop, head_valid)
   `PRS_ASSERT_NEXT(a_cnt_grows, clock, reset, push && !pop, cnt_ff == ($past(cnt_ff) + CNT_W'(1)))

endmodule

[rtl/prs_back.sv]
// ----------------------------------------------------------------------------
// prs_back
// Palette RAM, lookup stage and output register for pixel results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module prs_back #(
   parameter int PALETTE_DEPTH = prs_pkg::PALETTE_DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  prs_pkg::cfg_type   cfg,
   input  logic               head_valid,
   input  prs_pkg::entry_type head_entry,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output prs_pkg::rsp_type   rsp_payload
);

   localparam int AW = $clog2(PALETTE_DEPTH);

   logic               s1_valid_ff, s1_valid_in;
   prs_pkg::entry_type s1_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   prs_pkg::rsp_type   rsp_ff, rsp_in;

   logic               out_free, out_load, adv;
   logic               is_write, is_pixel;
   logic [23:0]        rd_data;
   logic [7:0]         r, g, b, a;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign out_load = s1_valid_ff && out_free;
   assign adv      = !s1_valid_ff || out_free;
   assign pop      = adv && head_valid;
   assign is_write = head_entry.kind == prs_pkg::KIND_WRITE;
   assign is_pixel = head_entry.kind == prs_pkg::KIND_PIXEL;

   prs_ram #(
      .WIDTH(24),
      .DEPTH(PALETTE_DEPTH)
   ) u_palette (
      .clock  (clock),
      .wr_en  (pop && is_write && head_entry.in_range),
      .wr_addr(head_entry.index[AW-1:0]),
      .wr_data(head_entry.rgb),
      .rd_en  (pop && is_pixel),
      .rd_addr(head_entry.index[AW-1:0]),
      .rd_data(rd_data)
   );

   always_comb begin
      if (pop && !is_write) begin
         s1_valid_in = 1'b1;
      end else if (out_load) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // colour source per kind, then channel order per mode
   always_comb begin
      case (s1_ff.kind)
         prs_pkg::KIND_KEY: begin
            r = cfg.key_red;
            g = cfg.key_green;
            b = cfg.key_blue;
            a = prs_pkg::ALPHA_CLEAR;
         end
         prs_pkg::KIND_PIXEL: begin
            {r, g, b} = s1_ff.in_range ? rd_data : 24'd0;
            a = prs_pkg::ALPHA_OPAQUE;
         end
         default: begin
            r = 8'd0;
            g = 8'd0;
            b = 8'd0;
            a = 8'd0;
         end
      endcase
      if (cfg.out_mode == prs_pkg::MODE_BGRA) begin
         rsp_in.chan_first = b;
         rsp_in.chan_third = r;
      end else begin
         rsp_in.chan_first = r;
         rsp_in.chan_third = b;
      end
      rsp_in.chan_second  = g;
      rsp_in.alpha        = (cfg.out_mode inside {prs_pkg::MODE_RGBA, prs_pkg::MODE_BGRA})
                            ? a : 8'd0;
      rsp_in.repeat_res   = s1_ff.repeat_res;
      rsp_in.end_of_frame = s1_ff.end_of_frame;
      rsp_in.error_code   = s1_ff.error_code;
   end

   always_ff @(posedge clock) begin
      if (pop && !is_write) begin
         s1_ff <= head_entry;
      end
      if (out_load) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

[rtl/palette_rle_sprite_decoder_unit.sv]
// A result passes the queue, lookup register and output register before it is
// valid on rsp_. Throughput: one input item per cycle unless rsp_ready stalls;
// a palette write or a control byte that announces a literal run makes no
// result. The single palette RAM read port sets the rate, one lookup a cycle.
// Reset is synchronous, active high: run state, position, queue and output
// valid clear at once; the palette is not cleared and holds junk until written.
// ----------------------------------------------------------------------------
// palette_rle_sprite_decoder_unit
// Run-length sprite decoder with palette lookup, top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module palette_rle_sprite_decoder_unit #(
   parameter int PALETTE_DEPTH = prs_pkg::PALETTE_DEPTH_DEF,
   parameter int POSITION_BITS = prs_pkg::POSITION_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  prs_pkg::req_type                  req_payload,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output prs_pkg::rsp_type                  rsp_payload,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [prs_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [prs_pkg::FRAME_W-1:0]       csr_data
);

   // Structure:
   //   front - takes each transfer, keeps literal count, pixel position and
   //           overrun flag, and decides kind, repeat count and error code.
   //   queue - four entries so front and back stall independently.
   //   back  - applies palette writes, reads the palette for literal
   //           pixels, and formats the colour channels into the output reg.
   // Palette writes travel through the queue, so a later pixel lookup always
   // sees an earlier write in order.

   prs_pkg::cfg_type            cfg_ff;
   logic [prs_pkg::FRAME_W-1:0] frame_pixels_ff;

   logic               queue_full;
   logic               push;
   prs_pkg::entry_type push_entry;
   logic               pop;
   logic               head_valid;
   prs_pkg::entry_type head_entry;

   // configuration registers; writes are always taken
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.key_red   <= prs_pkg::KEY_RST;
         cfg_ff.key_green <= prs_pkg::KEY_RST;
         cfg_ff.key_blue  <= prs_pkg::KEY_RST;
         cfg_ff.out_mode  <= prs_pkg::MODE_RGB;
         frame_pixels_ff  <= prs_pkg::FRAME_PIXELS_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            prs_pkg::REG_KEY_RED:      cfg_ff.key_red   <= csr_data[7:0];
            prs_pkg::REG_KEY_GREEN:    cfg_ff.key_green <= csr_data[7:0];
            prs_pkg::REG_KEY_BLUE:     cfg_ff.key_blue  <= csr_data[7:0];
            prs_pkg::REG_OUT_MODE:     cfg_ff.out_mode  <= csr_data[1:0];
            prs_pkg::REG_FRAME_PIXELS: frame_pixels_ff  <= csr_data;
            default: begin
            end
         endcase
      end
   end

   prs_front #(
      .PALETTE_DEPTH(PALETTE_DEPTH),
      .POSITION_BITS(POSITION_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .frame_pixels(frame_pixels_ff),
      .queue_full  (queue_full),
      .push        (push),
      .push_entry  (push_entry)
   );

   prs_fifo u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_entry(push_entry),
      .full      (queue_full),
      .pop       (pop),
      .head_valid(head_valid),
      .head_entry(head_entry)
   );

   prs_back #(
      .PALETTE_DEPTH(PALETTE_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_payload(rsp_payload)
   );

endmodule

[dv/prs_pixel_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prs_pixel_checker
// Watches the request, result and register channels of the sprite decoder,
// predicts every pixel result and compares each one field by field.
// ----------------------------------------------------------------------------

module prs_pixel_checker
   import prs_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  req_type                req_payload,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  rsp_type                rsp_payload,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [FRAME_W-1:0]     csr_data,
   output int                     fail_count,
   output int                     pending,
   output int                     results_checked
);

   localparam longint unsigned POS_MAX = (64'd1 << POSITION_BITS_DEF) - 64'd1;
   localparam int PRINT_MAX = 40;

   logic [23:0]        palette [PALETTE_DEPTH_DEF];
   logic [7:0]         key_r, key_g, key_b;
   logic [1:0]         mode;
   logic [FRAME_W-1:0] frame_px;
   logic [7:0]         lit_left;
   longint unsigned    pix_pos;
   bit                 over_seen;
   rsp_type            pixels_due [$];
   int                 errors;
   int                 checked;

   assign fail_count      = errors;
   assign results_checked = checked;

   task automatic report(input string msg);
      if (errors < PRINT_MAX) $display("mismatch: %s", msg);
      errors++;
   endtask

   function automatic void clear_frame();
      lit_left  = 8'd0;
      pix_pos   = 0;
      over_seen = 1'b0;
   endfunction

   // position saturates at the frame size; sticky overrun for the frame
   function automatic bit advance_pos(input int unsigned n);
      longint unsigned lim;
      longint unsigned next_pos;
      lim = 64'(frame_px);
      if (lim > POS_MAX) lim = POS_MAX;
      next_pos = pix_pos + 64'(n);
      if (next_pos > lim) begin
         next_pos  = lim;
         over_seen = 1'b1;
      end
      pix_pos = next_pos;
      return over_seen;
   endfunction

   function automatic rsp_type pack_pixel(input logic [7:0] r, g, b, a,
                                          input logic [6:0] rep,
                                          input logic eof,
                                          input logic [1:0] err);
      rsp_type px;
      px = '0;
      if (mode == MODE_BGRA) begin
         px.chan_first = b;
         px.chan_third = r;
      end else begin
         px.chan_first = r;
         px.chan_third = b;
      end
      px.chan_second  = g;
      px.alpha        = (mode == MODE_RGBA || mode == MODE_BGRA) ? a : ALPHA_CLEAR;
      px.repeat_res   = rep;
      px.end_of_frame = eof;
      px.error_code   = err;
      return px;
   endfunction

   function automatic bit decode_item(input req_type it, output rsp_type px);
      logic [23:0] rgb;
      logic [7:0]  run;
      logic [1:0]  err;
      px = '0;
      if (it.cmd == CMD_PALETTE) begin
         palette[it.pal_index] = {it.pal_red, it.pal_green, it.pal_blue};
         return 1'b0;
      end
      if (lit_left == 8'd0) begin
         if (it.code_byte > CTRL_BASE) begin
            run = it.code_byte - CTRL_BASE;
            err = advance_pos(32'(run)) ? ERR_OVERRUN : ERR_OK;
            px  = pack_pixel(key_r, key_g, key_b, ALPHA_CLEAR, run[6:0], it.frame_end, err);
            if (it.frame_end) clear_frame();
            return 1'b1;
         end
         if (it.frame_end) begin
            // end marker: all colour fields zero
            if (it.code_byte != 8'd0) err = ERR_TRUNC;
            else err = over_seen ? ERR_OVERRUN : ERR_OK;
            px.end_of_frame = 1'b1;
            px.error_code   = err;
            clear_frame();
            return 1'b1;
         end
         lit_left = it.code_byte;
         return 1'b0;
      end
      rgb      = palette[it.code_byte];
      lit_left = lit_left - 8'd1;
      if (advance_pos(1)) err = ERR_OVERRUN;
      else if (it.frame_end && lit_left != 8'd0) err = ERR_TRUNC;
      else err = ERR_OK;
      px = pack_pixel(rgb[23:16], rgb[15:8], rgb[7:0], ALPHA_OPAQUE, 7'd1, it.frame_end, err);
      if (it.frame_end) clear_frame();
      return 1'b1;
   endfunction

   always @(posedge clock) begin : watch
      rsp_type want;
      rsp_type got;
      if (reset) begin
         key_r    = KEY_RST;
         key_g    = KEY_RST;
         key_b    = KEY_RST;
         mode     = MODE_RGB;
         frame_px = FRAME_PIXELS_RST;
         clear_frame();
         pixels_due.delete();
         pending <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_KEY_RED:      key_r    = csr_data[7:0];
               REG_KEY_GREEN:    key_g    = csr_data[7:0];
               REG_KEY_BLUE:     key_b    = csr_data[7:0];
               REG_OUT_MODE:     mode     = csr_data[1:0];
               REG_FRAME_PIXELS: frame_px = csr_data;
               default: ;
            endcase
         end
         // a result can't belong to a request taken at the same edge
         if (rsp_valid && rsp_ready) begin
            got = rsp_payload;
            if (pixels_due.size() == 0) begin
               report($sformatf("result %0d arrived with nothing expected", checked));
            end else begin
               want = pixels_due.pop_front();
               if (got.chan_first !== want.chan_first)
                  report($sformatf("result %0d chan_first got %02h want %02h",
                                   checked, got.chan_first, want.chan_first));
               if (got.chan_second !== want.chan_second)
                  report($sformatf("result %0d chan_second got %02h want %02h",
                                   checked, got.chan_second, want.chan_second));
               if (got.chan_third !== want.chan_third)
                  report($sformatf("result %0d chan_third got %02h want %02h",
                                   checked, got.chan_third, want.chan_third));
               if (got.alpha !== want.alpha)
                  report($sformatf("result %0d alpha got %02h want %02h",
                                   checked, got.alpha, want.alpha));
               if (got.repeat_res !== want.repeat_res)
                  report($sformatf("result %0d repeat_res got %0d want %0d",
                                   checked, got.repeat_res, want.repeat_res));
               if (got.end_of_frame !== want.end_of_frame)
                  report($sformatf("result %0d end_of_frame got %0b want %0b",
                                   checked, got.end_of_frame, want.end_of_frame));
               if (got.error_code !== want.error_code)
                  report($sformatf("result %0d error_code got %0d want %0d",
                                   checked, got.error_code, want.error_code));
            end
            checked++;
         end
         if (req_valid && req_ready) begin
            if (decode_item(req_payload, want)) pixels_due.push_back(want);
         end
         pending <= pixels_due.size();
      end
   end

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the palette RLE sprite decoder: directed frames,
// a full palette load, then random frames under several register settings,
// with random idling on both channels; the checker does all prediction.
// ----------------------------------------------------------------------------

module tb;
   import prs_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;  // cycles without any transfer
   localparam int HOLD_CYCLES    = 200;   // long receiver hold-off
   localparam int SETTLE_CYCLES  = 4;     // margin for result-less items to drain
   localparam int PHASES         = 8;
   localparam int PHASE_ITEMS    = 100;
   localparam logic [1:0] MODE_SPARE = 2'd3;  // unused code, decodes as RGB

   logic                   clock       = 1'b0;
   logic                   reset       = 1'b1;
   logic                   req_valid   = 1'b0;
   logic                   req_ready;
   req_type                req_payload = '0;
   logic                   rsp_valid;
   logic                   rsp_ready   = 1'b0;
   rsp_type                rsp_payload;
   logic                   csr_valid   = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index   = '0;
   logic [FRAME_W-1:0]     csr_data    = '0;

   int fail_count;
   int pending;
   int results_checked;
   int sent_items;
   int frames_sent;
   int settings_loaded;
   int idle_cycles;
   bit calm;       // no idling on either side
   bit stall_ask;  // asks the receiver for one long hold-off

   initial begin
      forever #1 clock = ~clock;
   end

   palette_rle_sprite_decoder_unit u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   prs_pixel_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_payload     (req_payload),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_payload     (rsp_payload),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .fail_count      (fail_count),
      .pending         (pending),
      .results_checked (results_checked)
   );

   // Watchdog: any transfer on any channel resets the count.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles", idle_cycles);
         $display("TB_ERROR");
         $finish;
      end
   end

   // Receiver: random hold-off bursts, one long hold-off on request,
   // always ready once the run goes calm.
   initial begin
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (stall_ask) begin
            stall_ask = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_ready <= 1'b1;
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b1;
         end
         @(posedge clock);
      end
   end

   // One request transfer; entered and left at a rising-edge step, valid
   // stays high between back-to-back items.
   task automatic push_item(input req_type it);
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= it;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent_items++;
   endtask

   task automatic send_code(input logic [7:0] code, input logic eof);
      req_type it;
      it           = '0;
      it.cmd       = CMD_FRAME;
      it.pal_index = 8'($urandom_range(0, 255));  // don't-care on frame bytes
      it.pal_red   = 8'($urandom_range(0, 255));
      it.pal_green = 8'($urandom_range(0, 255));
      it.pal_blue  = 8'($urandom_range(0, 255));
      it.code_byte = code;
      it.frame_end = eof;
      push_item(it);
   endtask

   task automatic send_palette(input logic [7:0] idx, r, g, b);
      req_type it;
      it           = '0;
      it.cmd       = CMD_PALETTE;
      it.pal_index = idx;
      it.pal_red   = r;
      it.pal_green = g;
      it.pal_blue  = b;
      it.code_byte = 8'($urandom_range(0, 255));  // ignored on palette writes
      it.frame_end = 1'($urandom_range(0, 1));
      push_item(it);
   endtask

   // Sender pause: hold off until every expected result has come back,
   // then let the pipeline empty of result-less items too.
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Leaves csr_valid high; load_settings lowers it after the last write.
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [FRAME_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic load_settings(input logic [7:0] kr, kg, kb,
                                input logic [1:0] out_mode,
                                input logic [FRAME_W-1:0] px);
      write_reg(REG_KEY_RED, FRAME_W'(kr));
      write_reg(REG_KEY_GREEN, FRAME_W'(kg));
      write_reg(REG_KEY_BLUE, FRAME_W'(kb));
      write_reg(REG_OUT_MODE, FRAME_W'(out_mode));
      write_reg(REG_FRAME_PIXELS, px);
      csr_valid <= 1'b0;
      @(posedge clock);
      settings_loaded++;
   endtask

   // Literal run length: mostly short, now and then up to the full 128.
   function automatic int run_len();
      if ($urandom_range(0, 15) == 0) return $urandom_range(1, 128);
      return $urandom_range(1, 6);
   endfunction

   // Well-formed frame with random content, closed in one of several ways,
   // some of them truncated.
   task automatic send_frame();
      int segs;
      int kind;
      int n;
      int cut;
      int s;
      int k;
      segs = $urandom_range(1, 6);
      for (s = 0; s < segs; s++) begin
         kind = $urandom_range(0, 9);
         if (kind < 4) begin
            send_code(8'(8'h81 + $urandom_range(0, 126)), 1'b0);
         end else if (kind < 8) begin
            n = run_len();
            send_code(8'(n), 1'b0);
            for (k = 0; k < n; k++) send_code(8'($urandom_range(0, 255)), 1'b0);
         end else if (kind == 8) begin
            // palette update in mid-frame
            send_palette(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                         8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
         end else begin
            send_code(8'h00, 1'b0);
         end
      end
      kind = $urandom_range(0, 9);
      if (kind < 3) begin
         send_code(8'(8'h81 + $urandom_range(0, 126)), 1'b1);
      end else if (kind < 6) begin
         n = run_len();
         send_code(8'(n), 1'b0);
         for (k = 0; k < n; k++) send_code(8'($urandom_range(0, 255)), k == n - 1);
      end else if (kind == 6) begin
         send_code(8'h00, 1'b1);
      end else if (kind == 7) begin
         // frame ends on a control byte that announced a run
         send_code(8'(run_len()), 1'b1);
      end else begin
         // frame ends in the middle of a literal run
         n = run_len();
         if (n < 2) n = 2;
         send_code(8'(n), 1'b0);
         cut = $urandom_range(1, n - 1);
         for (k = 0; k < cut; k++) send_code(8'($urandom_range(0, 255)), k == cut - 1);
      end
      frames_sent++;
   endtask

   // Unstructured items: any byte, stray frame ends, stray palette writes.
   task automatic send_noise(input int count);
      int k;
      for (k = 0; k < count; k++) begin
         if ($urandom_range(0, 4) == 0) begin
            send_palette(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                         8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
         end else begin
            send_code(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
         end
      end
   endtask

   // Every entry written once in random order, so any later index is legal.
   task automatic fill_palette();
      logic [7:0] order [256];
      logic [7:0] swap;
      int i;
      int j;
      for (i = 0; i < 256; i++) order[i] = 8'(i);
      for (i = 255; i > 0; i--) begin
         j        = $urandom_range(0, i);
         swap     = order[i];
         order[i] = order[j];
         order[j] = swap;
      end
      for (i = 0; i < 256; i++) begin
         send_palette(order[i], 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)));
      end
   endtask

   initial begin : stimulus
      int ph;
      int budget;
      logic [7:0] kr, kg, kb;
      logic [FRAME_W-1:0] px;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // ---- directed part: only entries 00, 5A and FF are ever read ----
      load_settings(8'h00, 8'hFF, 8'h5A, MODE_RGBA, 21'd10);
      send_palette(8'h00, 8'hFF, 8'h00, 8'hA5);
      send_palette(8'hFF, 8'h00, 8'hFF, 8'h5A);
      send_palette(8'h5A, 8'h01, 8'h02, 8'h03);
      // clean pixels, a no-op control, a mid-frame palette write, then a
      // frame end on a control byte announcing 128 literals
      send_code(8'h83, 1'b0);
      send_code(8'h02, 1'b0);
      send_code(8'h00, 1'b0);
      send_code(8'hFF, 1'b0);
      send_code(8'h00, 1'b0);
      send_palette(8'h5A, 8'h80, 8'h7F, 8'hC3);
      send_code(8'h01, 1'b0);
      send_code(8'h5A, 1'b0);
      send_code(8'h80, 1'b1);
      // longest key run overruns; overrun sticks to the pixel and the marker
      send_code(8'hFF, 1'b0);
      send_code(8'h01, 1'b0);
      send_code(8'h00, 1'b0);
      send_code(8'h00, 1'b1);
      // literal run cut off by the frame end
      send_code(8'h03, 1'b0);
      send_code(8'h00, 1'b0);
      send_code(8'hFF, 1'b1);
      // key run carrying the frame end
      send_code(8'h85, 1'b1);
      frames_sent += 4;
      wait_drained();
      // empty frame: overrun wins over truncation on a pixel
      load_settings(8'hFF, 8'h00, 8'hA5, MODE_BGRA, 21'd0);
      send_code(8'h02, 1'b0);
      send_code(8'hFF, 1'b1);
      frames_sent++;
      wait_drained();
      // spare mode code behaves as RGB
      load_settings(8'h5A, 8'hA5, 8'hFF, MODE_SPARE, FRAME_PIXELS_RST);
      send_code(8'h81, 1'b1);
      send_code(8'h00, 1'b1);
      frames_sent += 2;
      wait_drained();

      // ---- random part ----
      fill_palette();
      for (ph = 0; ph < PHASES; ph++) begin
         calm = (ph >= PHASES - 2);
         wait_drained();
         if (ph == 0) begin
            kr = 8'h00; kg = 8'h00; kb = 8'h00;
         end else if (ph == 1) begin
            kr = 8'hFF; kg = 8'hFF; kb = 8'hFF;
         end else begin
            kr = 8'($urandom_range(0, 255));
            kg = 8'($urandom_range(0, 255));
            kb = 8'($urandom_range(0, 255));
         end
         case (ph)
            0:       px = 21'd0;
            1:       px = FRAME_PIXELS_RST;
            2:       px = 21'd5;
            3:       px = 21'd60;
            4:       px = 21'd1000;
            5:       px = FRAME_W'($urandom_range(0, 300));
            6:       px = 21'd30;
            default: px = FRAME_PIXELS_RST;
         endcase
         load_settings(kr, kg, kb, 2'(ph % 3), px);
         budget = sent_items + PHASE_ITEMS;
         if (ph == 2) stall_ask = 1'b1;  // sender keeps offering meanwhile
         while (sent_items < budget) begin
            if (ph == 4 && sent_items > budget - PHASE_ITEMS / 2 &&
                sent_items <= budget - PHASE_ITEMS / 2 + 20) begin
               wait_drained();  // sender pause in mid-stream
            end
            if ($urandom_range(0, 6) == 0) send_noise($urandom_range(3, 10));
            send_frame();
         end
      end

      wait_drained();
      if (pending != 0) $display("%0d expected results never arrived", pending);
      $display("covered %0d request transfers in %0d frames under %0d register settings",
               sent_items, frames_sent, settings_loaded);
      $display("%0d results compared, %0d mismatches", results_checked, fail_count);
      if (fail_count == 0 && pending == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

[filelist.f]
+incdir+rtl
rtl/prs_pkg.sv
rtl/prs_ram.sv
rtl/prs_front.sv
rtl/prs_fifo.sv
rtl/prs_back.sv
rtl/palette_rle_sprite_decoder_unit.sv
dv/prs_pixel_checker.sv
dv/tb.sv
